// ----- hw/rtl/progress_rate_eta_estimator_macros.svh -----
// assertion macros shared by the checker files of the progress rate eta estimator
`ifndef PROGRESS_RATE_ETA_ESTIMATOR_MACROS_SVH
`define PROGRESS_RATE_ETA_ESTIMATOR_MACROS_SVH

// property that must hold in the same cycle as its trigger
`define PRETE_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("prete checker: same-cycle property failed");

// property that must hold in the cycle after its trigger
`define PRETE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("prete checker: next-cycle property failed");

`endif

// ----- hw/rtl/prete_pkg.sv -----
// shared widths, register codes, reset values and control structs of the eta estimator
`timescale 1ns / 1ps
`default_nettype none

package prete_pkg;

  // field and register widths
  localparam int unsigned TIME_W     = 48;
  localparam int unsigned LEVEL_W    = 15;
  localparam int unsigned RATE_W     = 40;
  localparam int unsigned INTERVAL_W = 16;
  localparam int unsigned WEIGHT_W   = 9;
  localparam int unsigned MINRATE_W  = 16;
  localparam int unsigned CFG_DATA_W = 40;
  localparam int unsigned CFG_IDX_W  = 3;

  // shared restoring divider
  localparam int unsigned DIV_NUM_W = 33;
  localparam int unsigned DIV_DEN_W = 48;
  localparam int unsigned DIV_CNT_W = 6;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS   = DIV_CNT_W'(DIV_NUM_W);
  localparam logic [DIV_CNT_W-1:0] DIV_CNT_ONE = DIV_CNT_W'(1);

  // product widths for the blend and decay
  localparam int unsigned PROD_W       = WEIGHT_W + DIV_NUM_W;
  localparam int unsigned MULT_W       = WEIGHT_W + RATE_W;
  localparam int unsigned WEIGHT_SHIFT = 8;
  localparam int unsigned ETA_SHIFT    = 16;

  // arithmetic constants
  localparam logic [LEVEL_W-1:0]  FULL_LEVEL = 15'd25600;
  localparam logic [17:0]         RATE_SCALE = 18'd256000;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 9'd256;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_INTERVAL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EMA_WEIGHT      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STALL_DECAY     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RATE        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RATE        = 3'd4;

  // register reset values
  localparam logic [INTERVAL_W-1:0] RST_SAMPLE_INTERVAL = 16'd250;
  localparam logic [WEIGHT_W-1:0]   RST_EMA_WEIGHT      = 9'd77;
  localparam logic [WEIGHT_W-1:0]   RST_STALL_DECAY     = 9'd230;
  localparam logic [RATE_W-1:0]     RST_MAX_RATE        = 40'd655360000;
  localparam logic [MINRATE_W-1:0]  RST_MIN_RATE        = 16'd655;

  // commands from controller to datapath
  typedef struct packed {
    logic load_in;
    logic clr_state;
    logic store_smp;
    logic stall_rate;
    logic rdiv_start;
    logic mul_inst;
    logic upd_rate;
    logic ediv_start;
    logic out_load;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic is_clr;
    logic first_smp;
    logic skip_smp;
    logic pos_chg;
    logic dt_zero;
    logic stall_cond;
    logic eta_ok;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/prete_div.sv -----
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module prete_div (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start_i,
  input  wire logic [prete_pkg::DIV_NUM_W-1:0]    num_i,
  input  wire logic [prete_pkg::DIV_DEN_W-1:0]    den_i,
  output logic                                    done_o,
  output logic [prete_pkg::DIV_NUM_W-1:0]         quo_o
);

  logic [prete_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                            done_q, done_d;
  logic [prete_pkg::DIV_DEN_W-1:0] rem_q, rem_d;
  logic [prete_pkg::DIV_NUM_W-1:0] work_q, work_d;
  logic [prete_pkg::DIV_DEN_W-1:0] den_q, den_d;
  logic [prete_pkg::DIV_DEN_W:0]   rem_sh;
  logic [prete_pkg::DIV_DEN_W:0]   rem_sub;
  logic                            ge;

  // one trial subtraction per step
  always_comb begin
    rem_sh  = {rem_q, work_q[prete_pkg::DIV_NUM_W-1]};
    ge      = rem_sh >= {1'b0, den_q};
    rem_sub = rem_sh - {1'b0, den_q};
  end

  // step sequencing; dividend bits shift out as quotient bits shift in
  always_comb begin
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    work_d = work_q;
    den_d  = den_q;
    done_d = 1'b0;
    if (start_i) begin
      cnt_d  = prete_pkg::DIV_STEPS;
      rem_d  = '0;
      work_d = num_i;
      den_d  = den_i;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - prete_pkg::DIV_CNT_ONE;
      rem_d  = ge ? rem_sub[prete_pkg::DIV_DEN_W-1:0] : rem_sh[prete_pkg::DIV_DEN_W-1:0];
      work_d = {work_q[prete_pkg::DIV_NUM_W-2:0], ge};
      done_d = (cnt_q == prete_pkg::DIV_CNT_ONE);
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    work_q <= work_d;
    den_q  <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = work_q;

endmodule

`default_nettype wire

// ----- hw/rtl/prete_dpath.sv -----
// estimator datapath: registers, sample state, rate arithmetic, divider and output register
`timescale 1ns / 1ps
`default_nettype none

module prete_dpath (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // register write port
  input  wire logic                                cfg_we_i,
  input  wire logic [prete_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [prete_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // input beat payload
  input  wire logic                                command_i,
  input  wire logic [prete_pkg::TIME_W-1:0]        time_ms_i,
  input  wire logic [prete_pkg::LEVEL_W-1:0]       progress_level_i,
  // output beat
  input  wire logic                                out_stall_i,
  output logic                                     out_valid_o,
  output logic                                     eta_valid_o,
  output logic [prete_pkg::RATE_W-1:0]             eta_time_o,
  output logic [prete_pkg::RATE_W-1:0]             rate_now_o,
  // controller link
  input  wire prete_pkg::cmd_t                     cmd_i,
  output prete_pkg::sts_t                          sts_o
);

  // clamp a weight at one
  function automatic logic [prete_pkg::WEIGHT_W-1:0] sat_weight(
    input logic [prete_pkg::WEIGHT_W-1:0] w
  );
    return (w > prete_pkg::WEIGHT_ONE) ? prete_pkg::WEIGHT_ONE : w;
  endfunction

  // configuration registers
  logic [prete_pkg::INTERVAL_W-1:0] interval_q;
  logic [prete_pkg::WEIGHT_W-1:0]   weight_q;
  logic [prete_pkg::WEIGHT_W-1:0]   decay_q;
  logic [prete_pkg::RATE_W-1:0]     max_rate_q;
  logic [prete_pkg::MINRATE_W-1:0]  min_rate_q;

  // latched input beat
  logic                             cmd_q;
  logic [prete_pkg::TIME_W-1:0]     time_q;
  logic [prete_pkg::LEVEL_W-1:0]    lvl_q;

  // estimator state
  logic [prete_pkg::TIME_W-1:0]     last_time_q;
  logic [prete_pkg::LEVEL_W-1:0]    last_level_q;
  logic [prete_pkg::RATE_W-1:0]     smoothed_q;
  logic                             have_smp_q;
  logic                             have_rate_q;
  logic [prete_pkg::PROD_W-1:0]     prod_q;

  // output register
  logic                             out_valid_q;
  logic                             eta_valid_q;
  logic [prete_pkg::RATE_W-1:0]     eta_time_q;
  logic [prete_pkg::RATE_W-1:0]     rate_now_q;

  // combinational datapath
  logic [prete_pkg::TIME_W:0]       dt_full;
  logic [prete_pkg::TIME_W-1:0]     dt;
  logic                             time_back;
  logic [prete_pkg::LEVEL_W-1:0]    chg;
  logic [prete_pkg::DIV_NUM_W-1:0]  rate_num;
  logic [prete_pkg::LEVEL_W-1:0]    rem_lvl;
  logic [prete_pkg::DIV_NUM_W-1:0]  eta_num;
  logic [prete_pkg::MINRATE_W-1:0]  floor_rate;
  logic [prete_pkg::RATE_W-1:0]     div_rate;
  logic [prete_pkg::WEIGHT_W-1:0]   w_sat;
  logic [prete_pkg::WEIGHT_W-1:0]   inv_w;
  logic [prete_pkg::WEIGHT_W-1:0]   d_sat;
  logic [prete_pkg::MULT_W-1:0]     blend_mul;
  logic [prete_pkg::MULT_W-1:0]     blend_sum;
  logic [prete_pkg::MULT_W-1:0]     stall_mul;
  logic                             in_range;
  logic                             eta_ok;

  // divider link
  logic                             div_start;
  logic [prete_pkg::DIV_NUM_W-1:0]  div_num;
  logic [prete_pkg::DIV_DEN_W-1:0]  div_den;
  logic                             div_done;
  logic [prete_pkg::DIV_NUM_W-1:0]  quo;

  // sample timing and progress change
  always_comb begin
    dt_full   = {1'b0, time_q} - {1'b0, last_time_q};
    dt        = dt_full[prete_pkg::TIME_W-1:0];
    time_back = dt_full[prete_pkg::TIME_W];
    chg       = lvl_q - last_level_q;
    rate_num  = prete_pkg::DIV_NUM_W'(chg) * prete_pkg::DIV_NUM_W'(prete_pkg::RATE_SCALE);
  end

  // eta operands: remaining level over the floored rate
  always_comb begin
    rem_lvl    = prete_pkg::FULL_LEVEL - lvl_q;
    eta_num    = prete_pkg::DIV_NUM_W'({rem_lvl, {prete_pkg::ETA_SHIFT{1'b0}}});
    floor_rate = (min_rate_q == '0) ? prete_pkg::MINRATE_W'(1) : min_rate_q;
    div_rate   = (smoothed_q > prete_pkg::RATE_W'(floor_rate)) ? smoothed_q
                                                               : prete_pkg::RATE_W'(floor_rate);
    eta_ok     = !cmd_q && have_rate_q && (lvl_q != '0) && (lvl_q < prete_pkg::FULL_LEVEL);
  end

  // blend and decay arithmetic
  always_comb begin
    w_sat     = sat_weight(weight_q);
    inv_w     = prete_pkg::WEIGHT_ONE - w_sat;
    d_sat     = sat_weight(decay_q);
    blend_mul = prete_pkg::MULT_W'(inv_w) * prete_pkg::MULT_W'(smoothed_q);
    blend_sum = prete_pkg::MULT_W'(prod_q) + blend_mul;
    stall_mul = prete_pkg::MULT_W'(d_sat) * prete_pkg::MULT_W'(smoothed_q);
    in_range  = prete_pkg::RATE_W'(quo) <= max_rate_q;
  end

  // shared divider
  assign div_start = cmd_i.rdiv_start | cmd_i.ediv_start;
  assign div_num   = cmd_i.rdiv_start ? rate_num : eta_num;
  assign div_den   = cmd_i.rdiv_start ? dt : prete_pkg::DIV_DEN_W'(div_rate);

  prete_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= prete_pkg::RST_SAMPLE_INTERVAL;
      weight_q   <= prete_pkg::RST_EMA_WEIGHT;
      decay_q    <= prete_pkg::RST_STALL_DECAY;
      max_rate_q <= prete_pkg::RST_MAX_RATE;
      min_rate_q <= prete_pkg::RST_MIN_RATE;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        prete_pkg::CFG_SAMPLE_INTERVAL: interval_q <= cfg_data_i[prete_pkg::INTERVAL_W-1:0];
        prete_pkg::CFG_EMA_WEIGHT:      weight_q   <= cfg_data_i[prete_pkg::WEIGHT_W-1:0];
        prete_pkg::CFG_STALL_DECAY:     decay_q    <= cfg_data_i[prete_pkg::WEIGHT_W-1:0];
        prete_pkg::CFG_MAX_RATE:        max_rate_q <= cfg_data_i[prete_pkg::RATE_W-1:0];
        prete_pkg::CFG_MIN_RATE:        min_rate_q <= cfg_data_i[prete_pkg::MINRATE_W-1:0];
        default: ;
      endcase
    end
  end

  // input beat capture and blend product
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      cmd_q  <= command_i;
      time_q <= time_ms_i;
      lvl_q  <= progress_level_i;
    end
    if (cmd_i.mul_inst) begin
      prod_q <= prete_pkg::PROD_W'(w_sat) * prete_pkg::PROD_W'(quo);
    end
  end

  // estimator state updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_time_q  <= '0;
      last_level_q <= '0;
      smoothed_q   <= '0;
      have_smp_q   <= 1'b0;
      have_rate_q  <= 1'b0;
    end else if (cmd_i.clr_state) begin
      last_time_q  <= '0;
      last_level_q <= '0;
      smoothed_q   <= '0;
      have_smp_q   <= 1'b0;
      have_rate_q  <= 1'b0;
    end else begin
      if (cmd_i.store_smp) begin
        last_time_q  <= time_q;
        last_level_q <= lvl_q;
        have_smp_q   <= 1'b1;
      end
      if (cmd_i.stall_rate && have_rate_q) begin
        smoothed_q <= stall_mul[prete_pkg::RATE_W+prete_pkg::WEIGHT_SHIFT-1:
                                prete_pkg::WEIGHT_SHIFT];
      end
      if (cmd_i.upd_rate && in_range) begin
        smoothed_q  <= have_rate_q
                       ? blend_sum[prete_pkg::RATE_W+prete_pkg::WEIGHT_SHIFT-1:
                                   prete_pkg::WEIGHT_SHIFT]
                       : prete_pkg::RATE_W'(quo);
        have_rate_q <= 1'b1;
      end
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      eta_valid_q <= eta_ok;
      eta_time_q  <= eta_ok ? prete_pkg::RATE_W'(quo) : '0;
      rate_now_q  <= smoothed_q;
    end
  end

  // status to controller
  always_comb begin
    sts_o.is_clr     = cmd_q;
    sts_o.first_smp  = !have_smp_q;
    sts_o.skip_smp   = have_smp_q && (time_back || (dt < prete_pkg::TIME_W'(interval_q)));
    sts_o.pos_chg    = lvl_q > last_level_q;
    sts_o.dt_zero    = (dt == '0);
    sts_o.stall_cond = (lvl_q < last_level_q) || (dt != '0);
    sts_o.eta_ok     = eta_ok;
    sts_o.div_done   = div_done;
    sts_o.out_free   = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o = out_valid_q;
  assign eta_valid_o = eta_valid_q;
  assign eta_time_o  = eta_time_q;
  assign rate_now_o  = rate_now_q;

endmodule

`default_nettype wire

// ----- hw/rtl/prete_ctrl.sv -----
// estimator controller: sequences sample handling, the two divides and the output load
`timescale 1ns / 1ps
`default_nettype none

module prete_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire prete_pkg::sts_t  sts_i,
  output prete_pkg::cmd_t       cmd_o
);

  // state codes
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECIDE = 3'd1;
  localparam logic [2:0] ST_RDIV   = 3'd2;
  localparam logic [2:0] ST_RMUL   = 3'd3;
  localparam logic [2:0] ST_RUPD   = 3'd4;
  localparam logic [2:0] ST_ETA    = 3'd5;
  localparam logic [2:0] ST_EDIV   = 3'd6;
  localparam logic [2:0] ST_OUT    = 3'd7;

  logic [2:0] state_q, state_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_d = ST_ETA;
        if (sts_i.is_clr) begin
          cmd_o.clr_state = 1'b1;
        end else if (sts_i.first_smp) begin
          cmd_o.store_smp = 1'b1;
        end else if (sts_i.skip_smp) begin
          // late or too early: state left alone
        end else if (sts_i.pos_chg && !sts_i.dt_zero) begin
          cmd_o.rdiv_start = 1'b1;
          state_d          = ST_RDIV;
        end else if (sts_i.pos_chg) begin
          cmd_o.store_smp = 1'b1;
        end else if (sts_i.stall_cond) begin
          cmd_o.stall_rate = 1'b1;
          cmd_o.store_smp  = 1'b1;
        end else begin
          cmd_o.store_smp = 1'b1;
        end
      end
      ST_RDIV: begin
        if (sts_i.div_done) begin
          state_d = ST_RMUL;
        end
      end
      ST_RMUL: begin
        cmd_o.mul_inst = 1'b1;
        state_d        = ST_RUPD;
      end
      ST_RUPD: begin
        cmd_o.upd_rate  = 1'b1;
        cmd_o.store_smp = 1'b1;
        state_d         = ST_ETA;
      end
      ST_ETA: begin
        if (sts_i.eta_ok) begin
          cmd_o.ediv_start = 1'b1;
          state_d          = ST_EDIV;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_EDIV: begin
        if (sts_i.div_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

`default_nettype wire

// ----- hw/rtl/progress_rate_eta_estimator.sv -----
// progress rate and eta estimator: top level joining controller and datapath
// the accepted beat passes the decide and eta states to the output register load for clear, ignored or
//   stored samples; the eta divide adds its wait state, and a rate update adds divide, multiply and update
// throughput: one item at a time; both divides share one 33-step restoring divider, the next
//   beat is taken the cycle after the result enters the output register, which waits on a held one
// reset: asynchronous, active low; configuration registers take their reset values and state clears at once
`timescale 1ns / 1ps
`default_nettype none

module progress_rate_eta_estimator (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // configuration
  input  wire logic                               cfg_we_i,
  input  wire logic [prete_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [prete_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // input channel
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic                               command_i,
  input  wire logic [prete_pkg::TIME_W-1:0]       time_ms_i,
  input  wire logic [prete_pkg::LEVEL_W-1:0]      progress_level_i,
  // output channel
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic                                    eta_valid_o,
  output logic [prete_pkg::RATE_W-1:0]            eta_time_o,
  output logic [prete_pkg::RATE_W-1:0]            rate_now_o
);

  prete_pkg::cmd_t cmd;
  prete_pkg::sts_t sts;

  // sequencer
  prete_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // arithmetic and storage
  prete_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .command_i        (command_i),
    .time_ms_i        (time_ms_i),
    .progress_level_i (progress_level_i),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .eta_valid_o      (eta_valid_o),
    .eta_time_o       (eta_time_o),
    .rate_now_o       (rate_now_o),
    .cmd_i            (cmd),
    .sts_o            (sts)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/prete_checker.sv -----
// port-level checker for the eta estimator, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "progress_rate_eta_estimator_macros.svh"

module prete_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             in_valid_i,
  input wire logic                             in_stall_o,
  input wire logic                             out_valid_o,
  input wire logic                             out_stall_i,
  input wire logic                             eta_valid_o,
  input wire logic [prete_pkg::RATE_W-1:0]     eta_time_o,
  input wire logic [prete_pkg::RATE_W-1:0]     rate_now_o
);

  // one item in flight: a taken beat closes the input side
  `PRETE_ASSERT_NEXT(a_one_in_flight, in_valid_i && !in_stall_o, in_stall_o)

  // an invalid eta reads as zero
  `PRETE_ASSERT_SAME(a_eta_zero, out_valid_o && !eta_valid_o, eta_time_o == '0)

  // remaining level times 65536 fits in 31 bits, so the eta never reaches the top bits
  `PRETE_ASSERT_SAME(a_eta_bound, out_valid_o, eta_time_o[prete_pkg::RATE_W-1:31] == '0)

  // a stalled result beat holds
  `PRETE_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
                     out_valid_o && $stable(eta_time_o) && $stable(rate_now_o))

endmodule

bind progress_rate_eta_estimator prete_checker u_prete_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .eta_valid_o (eta_valid_o),
  .eta_time_o  (eta_time_o),
  .rate_now_o  (rate_now_o)
);

`default_nettype wire

// ----- tb/sv/tb_progress_rate_eta_estimator.sv -----
// self-checking testbench for the progress rate and eta estimator
`timescale 1ns / 1ps

module tb_progress_rate_eta_estimator;
  import prete_pkg::*;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES    = 8;
  localparam int unsigned SETTLE_CYCLES   = 100;
  localparam int unsigned REPORT_LIMIT    = 10;
  localparam logic [RATE_W-1:0] RATE_ALL_ONES = '1;

  // one result beat
  typedef struct packed {
    logic              eta_valid;
    logic [RATE_W-1:0] eta_time;
    logic [RATE_W-1:0] rate_now;
  } eta_beat_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic                  command_i;
  logic [TIME_W-1:0]     time_ms_i;
  logic [LEVEL_W-1:0]    progress_level_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic                  eta_valid_o;
  logic [RATE_W-1:0]     eta_time_o;
  logic [RATE_W-1:0]     rate_now_o;

  progress_rate_eta_estimator dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .command_i        (command_i),
    .time_ms_i        (time_ms_i),
    .progress_level_i (progress_level_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .eta_valid_o      (eta_valid_o),
    .eta_time_o       (eta_time_o),
    .rate_now_o       (rate_now_o)
  );

  always #5 clk_i = ~clk_i;

  // register copies used by the predictor
  logic [INTERVAL_W-1:0] set_interval;
  logic [WEIGHT_W-1:0]   set_weight;
  logic [WEIGHT_W-1:0]   set_decay;
  logic [RATE_W-1:0]     set_max_rate;
  logic [MINRATE_W-1:0]  set_min_rate;

  // estimator state copy
  logic [TIME_W-1:0]  est_last_time;
  logic [LEVEL_W-1:0] est_last_level;
  logic [RATE_W-1:0]  est_rate;
  logic               est_have_sample;
  logic               est_have_rate;
  logic               beat_skipped;

  eta_beat_t eta_expected[$];

  int unsigned fail_count;
  int unsigned beats_sent;
  int unsigned clears_sent;
  int unsigned skipped_beats;
  int unsigned results_checked;
  int unsigned valid_etas;
  int unsigned settings_used;

  // idling control shared with the stall process
  logic        in_gaps_on;
  logic        out_gaps_on;
  int unsigned hold_off_asks;
  int unsigned hold_off_seen;
  int unsigned stall_left;

  function automatic int unsigned draw_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [63:0] clip_weight(input logic [WEIGHT_W-1:0] wgt);
    return (wgt > WEIGHT_ONE) ? 64'(WEIGHT_ONE) : 64'(wgt);
  endfunction

  // advance the estimator copy by one beat and work out its eta result
  function automatic eta_beat_t predict_eta(input logic cmd, input logic [TIME_W-1:0] t,
                                            input logic [LEVEL_W-1:0] lvl);
    eta_beat_t   res;
    logic [63:0] dt;
    logic [63:0] inst;
    logic [63:0] wgt;
    logic [63:0] floor_rate;
    logic [63:0] divisor;
    logic [63:0] eta;
    res = '0;
    beat_skipped = 1'b0;
    dt = 64'(t) - 64'(est_last_time);
    if (cmd == CMD_CLEAR) begin
      est_last_time   = '0;
      est_last_level  = '0;
      est_rate        = '0;
      est_have_sample = 1'b0;
      est_have_rate   = 1'b0;
    end else if (!est_have_sample) begin
      est_last_time   = t;
      est_last_level  = lvl;
      est_have_sample = 1'b1;
    end else if (t < est_last_time || dt < 64'(set_interval)) begin
      beat_skipped = 1'b1;
    end else begin
      if (lvl > est_last_level) begin
        // zero elapsed time with a rise counts as too fast
        if (dt != 0) begin
          inst = ((64'(lvl) - 64'(est_last_level)) * 64'(RATE_SCALE)) / dt;
          if (inst <= 64'(set_max_rate)) begin
            if (est_have_rate) begin
              wgt = clip_weight(set_weight);
              est_rate = RATE_W'((wgt * inst + (64'(WEIGHT_ONE) - wgt) * 64'(est_rate))
                                 >> WEIGHT_SHIFT);
            end else begin
              est_rate = RATE_W'(inst);
            end
            est_have_rate = 1'b1;
          end
        end
      end else if (lvl < est_last_level || dt != 0) begin
        if (est_have_rate) begin
          est_rate = RATE_W'((64'(est_rate) * clip_weight(set_decay)) >> WEIGHT_SHIFT);
        end
      end
      est_last_time  = t;
      est_last_level = lvl;
    end
    if (cmd == CMD_SAMPLE && est_have_rate && lvl != 0 && lvl < FULL_LEVEL) begin
      floor_rate = (set_min_rate == 0) ? 64'd1 : 64'(set_min_rate);
      divisor = (64'(est_rate) > floor_rate) ? 64'(est_rate) : floor_rate;
      eta = ((64'(FULL_LEVEL) - 64'(lvl)) << ETA_SHIFT) / divisor;
      res.eta_time  = (eta > 64'(RATE_ALL_ONES)) ? RATE_ALL_ONES : RATE_W'(eta);
      res.eta_valid = 1'b1;
    end
    res.rate_now = est_rate;
    return res;
  endfunction

  // offer one input beat after a random gap and record its expected result
  task automatic send_beat(input logic cmd, input logic [TIME_W-1:0] t,
                           input logic [LEVEL_W-1:0] lvl);
    int unsigned gap;
    eta_beat_t   next_beat;
    gap = in_gaps_on ? draw_gap() : 0;
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i       <= 1'b1;
    command_i        <= cmd;
    time_ms_i        <= t;
    progress_level_i <= lvl;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    next_beat = predict_eta(cmd, t, lvl);
    eta_expected = {eta_expected, next_beat};
    beats_sent++;
    if (cmd == CMD_CLEAR) clears_sent++;
    if (beat_skipped) skipped_beats++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    case (idx)
      CFG_SAMPLE_INTERVAL: set_interval = data[INTERVAL_W-1:0];
      CFG_EMA_WEIGHT:      set_weight   = data[WEIGHT_W-1:0];
      CFG_STALL_DECAY:     set_decay    = data[WEIGHT_W-1:0];
      CFG_MAX_RATE:        set_max_rate = data[RATE_W-1:0];
      CFG_MIN_RATE:        set_min_rate = data[MINRATE_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_settings(input logic [INTERVAL_W-1:0] interval,
                               input logic [WEIGHT_W-1:0] weight,
                               input logic [WEIGHT_W-1:0] decay,
                               input logic [RATE_W-1:0] top_rate,
                               input logic [MINRATE_W-1:0] floor_rate);
    write_reg(CFG_SAMPLE_INTERVAL, CFG_DATA_W'(interval));
    write_reg(CFG_EMA_WEIGHT, CFG_DATA_W'(weight));
    write_reg(CFG_STALL_DECAY, CFG_DATA_W'(decay));
    write_reg(CFG_MAX_RATE, CFG_DATA_W'(top_rate));
    write_reg(CFG_MIN_RATE, CFG_DATA_W'(floor_rate));
    settings_used++;
  endtask

  // stop offering and wait until every expected result has come back
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (eta_expected.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [RATE_W-1:0] random_max_rate();
    if ($urandom_range(0, 1) == 0) return RATE_W'({$urandom_range(0, 255), $urandom});
    return RATE_W'($urandom_range(100000, 700000000));
  endfunction

  // progress track: mostly well-formed samples, with clears, noise and stale times mixed in
  task automatic run_progress_track(input int unsigned target);
    int unsigned        used;
    int unsigned        roll;
    int                 lvl_next;
    logic [TIME_W-1:0]  t;
    logic [TIME_W-1:0]  dt;
    logic [LEVEL_W-1:0] lvl;
    used = 0;
    t = TIME_W'({$urandom, $urandom}) >> $urandom_range(0, 47);
    lvl = LEVEL_W'($urandom_range(0, 2000));
    while (used < target) begin
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        send_beat(CMD_CLEAR, TIME_W'({$urandom, $urandom}), LEVEL_W'($urandom));
      end else if (roll < 7) begin
        send_beat(CMD_SAMPLE, TIME_W'({$urandom, $urandom}), LEVEL_W'($urandom));
      end else if (roll < 11) begin
        send_beat(CMD_SAMPLE, t - TIME_W'($urandom_range(1, 5000)), lvl);
      end else begin
        // elapsed time around the interval, sometimes short or very long
        roll = $urandom_range(0, 99);
        if (roll < 75) dt = TIME_W'(set_interval) + TIME_W'($urandom_range(0, 1500));
        else if (roll < 88) dt = TIME_W'($urandom_range(0, set_interval));
        else if (roll < 95) dt = TIME_W'($urandom_range(300000, 3000000));
        else dt = TIME_W'(set_interval);
        t = t + dt;
        // progress steps: mostly rising, with stalls, drops and the ends of the range
        if (lvl >= FULL_LEVEL) begin
          lvl_next = int'($urandom_range(0, 300));
        end else begin
          roll = $urandom_range(0, 99);
          if (roll < 65) lvl_next = int'(lvl) + int'($urandom_range(1, 800));
          else if (roll < 75) lvl_next = int'(lvl) + int'($urandom_range(1000, 8000));
          else if (roll < 85) lvl_next = int'(lvl);
          else if (roll < 93) lvl_next = int'(lvl) - int'($urandom_range(1, 500));
          else if (roll < 95) lvl_next = int'(FULL_LEVEL);
          else if (roll < 97) lvl_next = 0;
          else lvl_next = int'($urandom_range(25601, 32767));
          if (lvl_next < 0) lvl_next = 0;
          if (roll < 75 && lvl_next > int'(FULL_LEVEL)) lvl_next = int'(FULL_LEVEL);
        end
        lvl = LEVEL_W'(lvl_next);
        send_beat(CMD_SAMPLE, t, lvl);
      end
      used++;
    end
  endtask

  // default registers: first sample, skips, blend, decay, ends of the range, clear
  task automatic test_reset_defaults();
    send_beat(CMD_SAMPLE, 48'd1000, 15'd0);
    send_beat(CMD_SAMPLE, 48'd1100, 15'd500);
    send_beat(CMD_SAMPLE, 48'd900, 15'd300);
    send_beat(CMD_SAMPLE, 48'd1250, 15'd256);
    send_beat(CMD_SAMPLE, 48'd1500, 15'd768);
    send_beat(CMD_SAMPLE, 48'd1750, 15'd768);
    send_beat(CMD_SAMPLE, 48'd2000, 15'd700);
    // rise so slow that the rate floors to zero
    send_beat(CMD_SAMPLE, 48'd302000, 15'd701);
    send_beat(CMD_SAMPLE, 48'd302250, FULL_LEVEL);
    send_beat(CMD_SAMPLE, 48'd302500, 15'h7fff);
    send_beat(CMD_SAMPLE, 48'd302501, 15'd0);
    send_beat(CMD_CLEAR, 48'hffff_ffff_ffff, 15'h7fff);
    send_beat(CMD_SAMPLE, 48'hffff_ffff_ff00, 15'd100);
    send_beat(CMD_SAMPLE, 48'hffff_ffff_ffff, 15'd25599);
  endtask

  // zero interval: equal timestamps, rate too fast, saturating weights, zero min rate
  task automatic test_zero_interval();
    drain();
    write_reg(CFG_SAMPLE_INTERVAL, '0);
    write_reg(CFG_EMA_WEIGHT, CFG_DATA_W'(511));
    write_reg(CFG_STALL_DECAY, CFG_DATA_W'(511));
    write_reg(CFG_MIN_RATE, '0);
    settings_used++;
    send_beat(CMD_CLEAR, 48'd0, 15'd0);
    send_beat(CMD_SAMPLE, 48'd5000, 15'd1000);
    send_beat(CMD_SAMPLE, 48'd5000, 15'd1200);
    send_beat(CMD_SAMPLE, 48'd5001, 15'd11200);
    send_beat(CMD_SAMPLE, 48'd5101, 15'd11300);
    send_beat(CMD_SAMPLE, 48'd5101, 15'd11200);
    send_beat(CMD_SAMPLE, 48'd5101, 15'd11200);
    send_beat(CMD_SAMPLE, 48'd5201, 15'd11300);
    send_beat(CMD_SAMPLE, 48'd305201, 15'd11301);
  endtask

  // several register settings, extremes first, then random ones
  task automatic test_random_settings();
    for (int phase = 0; phase < 8; phase++) begin
      drain();
      case (phase)
        0: load_settings('0, WEIGHT_ONE, WEIGHT_ONE, RATE_ALL_ONES, 16'd1);
        1: load_settings('1, '0, '0, '0, '1);
        2: load_settings(16'd1, '1, '1, random_max_rate(), '0);
        default: load_settings(INTERVAL_W'($urandom_range(0, 1000)),
                               WEIGHT_W'($urandom_range(0, 511)),
                               WEIGHT_W'($urandom_range(0, 511)),
                               random_max_rate(),
                               MINRATE_W'($urandom_range(0, 65535)));
      endcase
      in_gaps_on  = (phase != 4);
      out_gaps_on = (phase != 5);
      run_progress_track(125);
    end
    in_gaps_on  = 1'b1;
    out_gaps_on = 1'b1;
  endtask

  // receiver holds off for a long stretch while beats keep coming back to back
  task automatic test_backpressure();
    drain();
    load_settings(RST_SAMPLE_INTERVAL, RST_EMA_WEIGHT, RST_STALL_DECAY, RST_MAX_RATE,
                  RST_MIN_RATE);
    in_gaps_on  = 1'b0;
    out_gaps_on = 1'b0;
    hold_off_asks++;
    run_progress_track(24);
    in_gaps_on  = 1'b1;
    out_gaps_on = 1'b1;
  endtask

  // output stall: random gaps, plus a counted hold-off when asked
  initial begin
    out_stall_i   = 1'b0;
    hold_off_seen = 0;
    stall_left    = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off_seen != hold_off_asks) begin
        hold_off_seen = hold_off_asks;
        stall_left = HOLD_OFF_CYCLES;
      end
      if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
        if (out_gaps_on) stall_left = draw_gap();
      end
    end
  end

  // compare each result beat with the oldest expectation
  always @(posedge clk_i) begin
    eta_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_checked++;
      if (eta_expected.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("unexpected result: valid %0d eta %0d rate %0d",
                   eta_valid_o, eta_time_o, rate_now_o);
      end else begin
        want = eta_expected.pop_front();
        if (want.eta_valid) valid_etas++;
        if (eta_valid_o !== want.eta_valid || eta_time_o !== want.eta_time ||
            rate_now_o !== want.rate_now) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("mismatch on result %0d: valid %0d/%0d eta %0d/%0d rate %0d/%0d",
                     results_checked, want.eta_valid, eta_valid_o, want.eta_time,
                     eta_time_o, want.rate_now, rate_now_o);
        end
      end
    end
  end

  // watchdog
  initial begin
    #(10_000_000);
    $display("simulation failed");
    $finish;
  end

  initial begin
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_index_i      = '0;
    cfg_data_i       = '0;
    in_valid_i       = 1'b0;
    command_i        = CMD_SAMPLE;
    time_ms_i        = '0;
    progress_level_i = '0;
    in_gaps_on       = 1'b1;
    out_gaps_on      = 1'b1;
    hold_off_asks    = 0;
    fail_count       = 0;
    beats_sent       = 0;
    clears_sent      = 0;
    skipped_beats    = 0;
    results_checked  = 0;
    valid_etas       = 0;
    settings_used    = 1;
    beat_skipped     = 1'b0;
    set_interval     = RST_SAMPLE_INTERVAL;
    set_weight       = RST_EMA_WEIGHT;
    set_decay        = RST_STALL_DECAY;
    set_max_rate     = RST_MAX_RATE;
    set_min_rate     = RST_MIN_RATE;
    est_last_time    = '0;
    est_last_level   = '0;
    est_rate         = '0;
    est_have_sample  = 1'b0;
    est_have_rate    = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_zero_interval();
    test_random_settings();
    test_backpressure();

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("covered %0d beats under %0d register settings, %0d clears, %0d ignored samples",
             beats_sent, settings_used, clears_sent, skipped_beats);
    $display("checked %0d results, %0d of them with a valid eta", results_checked, valid_etas);
    if (fail_count == 0 && eta_expected.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/prete_pkg.sv
hw/rtl/prete_div.sv
hw/rtl/prete_dpath.sv
hw/rtl/prete_ctrl.sv
hw/rtl/progress_rate_eta_estimator.sv
hw/rtl/prete_checker.sv
tb/sv/tb_progress_rate_eta_estimator.sv
